@@ rtl/kmp_prefix_function_assert.svh @@
// ---------------------------------------------------------------------------
// kmp_prefix_function assertion macros
// Shared concurrent-check shorthands for the prefix function block.
// ---------------------------------------------------------------------------
`ifndef KMP_PREFIX_FUNCTION_ASSERT_SVH
`define KMP_PREFIX_FUNCTION_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define KPF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kmp_prefix_function: same-cycle check failed");

// Next-cycle implication, masked during reset.
`define KPF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kmp_prefix_function: next-cycle check failed");

`endif

@@ rtl/kpf_pkg.sv @@
// ---------------------------------------------------------------------------
// kpf_pkg
// Types and constants shared by the prefix function block.
// ---------------------------------------------------------------------------
package kpf_pkg;

  localparam int SYM_W      = 8;
  localparam int BORDER_W   = 12;
  localparam int QUEUE_DEPTH = 2;

  // How the back end has to treat a byte
  typedef enum logic [1:0] {
    KIND_FIRST,   // entry 0 of a string, border is zero
    KIND_NEXT,    // stored byte that needs the fallback walk
    KIND_OVF      // beyond capacity, not stored
  } kind_t;

  typedef struct packed {
    logic                overflow;
    logic [BORDER_W-1:0] border_length;
  } res_t;

endpackage

@@ rtl/kpf_fifo.sv @@
// ---------------------------------------------------------------------------
// kpf_fifo
// Small register queue with push/full and pop/valid sides.
// ---------------------------------------------------------------------------
module kpf_fifo #(
  parameter int WIDTH = 13
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             valid
);
  import kpf_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign valid    = (count_r != '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ rtl/kpf_front.sv @@
// ---------------------------------------------------------------------------
// kpf_front
// Input handshake, position tracking and byte classification.
// ---------------------------------------------------------------------------
module kpf_front #(
  parameter int MAX_LEN = 4096
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_push,
  output logic                                  in_full,
  input  logic [kpf_pkg::SYM_W-1:0]             in_symbol,
  input  logic                                  in_first,
  input  logic                                  q_full,
  output logic                                  cmd_push,
  output kpf_pkg::kind_t                        cmd_kind,
  output logic [kpf_pkg::SYM_W-1:0]             cmd_sym,
  output logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] cmd_idx
);
  import kpf_pkg::*;

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int PW = $clog2(MAX_LEN + 1);

  logic [PW-1:0] position_r, position_nxt;
  logic [PW-1:0] pos_eff;
  logic [PW-1:0] pos_step;

  assign in_full  = q_full;
  assign cmd_push = in_push && !q_full;
  assign cmd_sym  = in_symbol;

  always_comb begin
    pos_eff = in_first ? '0 : position_r;
    if (pos_eff == '0) begin
      cmd_kind = KIND_FIRST;
      cmd_idx  = '0;
      pos_step = PW'(1);
    end else if (pos_eff >= PW'(MAX_LEN)) begin
      // stays pinned at capacity until the next string starts
      cmd_kind = KIND_OVF;
      cmd_idx  = '0;
      pos_step = pos_eff;
    end else begin
      cmd_kind = KIND_NEXT;
      cmd_idx  = pos_eff[AW-1:0];
      pos_step = pos_eff + PW'(1);
    end
    position_nxt = cmd_push ? pos_step : position_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r <= '0;
    end else begin
      position_r <= position_nxt;
    end
  end

endmodule

@@ rtl/kpf_back.sv @@
// ---------------------------------------------------------------------------
// kpf_back
// Fallback walk over the stored bytes and border lengths.
// ---------------------------------------------------------------------------
module kpf_back #(
  parameter int MAX_LEN = 4096
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cmd_valid,
  input  kpf_pkg::kind_t                        cmd_kind,
  input  logic [kpf_pkg::SYM_W-1:0]             cmd_sym,
  input  logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] cmd_idx,
  output logic                                  cmd_pop,
  input  logic                                  res_full,
  output logic                                  res_push,
  output kpf_pkg::res_t                         res_d
);
  import kpf_pkg::*;

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_t;

  logic [SYM_W-1:0] text_mem [MAX_LEN];
  logic [AW-1:0]    bord_mem [MAX_LEN];

  state_t           state_r, state_nxt;
  logic [AW-1:0]    j_r, j_nxt;
  logic [AW-1:0]    last_j_r, last_j_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [SYM_W-1:0] sym_r, sym_nxt;

  logic [SYM_W-1:0] text_q_r;
  logic [AW-1:0]    bord_q_r;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    bord_rd_addr;
  logic             text_we, bord_we;
  logic [AW-1:0]    text_wa, bord_wa, bord_wd;
  logic             match;
  logic [AW-1:0]    res_j;
  logic             take_next;

  assign match        = (text_q_r == sym_r);
  assign res_j        = match ? j_r + AW'(1) : '0;
  assign bord_rd_addr = rd_addr - AW'(1);  // j == 0 reads a don't-care entry

  always_comb begin
    state_nxt  = state_r;
    j_nxt      = j_r;
    last_j_nxt = last_j_r;
    idx_nxt    = idx_r;
    sym_nxt    = sym_r;
    rd_addr    = j_r;
    text_we    = 1'b0;
    text_wa    = cmd_idx;
    bord_we    = 1'b0;
    bord_wa    = idx_r;
    bord_wd    = res_j;
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    res_d      = '0;
    take_next  = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          case (cmd_kind)
            KIND_NEXT: begin
              take_next = 1'b1;
            end
            KIND_FIRST: begin
              if (!res_full) begin
                cmd_pop    = 1'b1;
                text_we    = 1'b1;
                text_wa    = '0;
                bord_we    = 1'b1;
                bord_wa    = '0;
                bord_wd    = '0;
                last_j_nxt = '0;
                res_push   = 1'b1;
              end
            end
            KIND_OVF: begin
              if (!res_full) begin
                cmd_pop        = 1'b1;
                res_push       = 1'b1;
                res_d.overflow = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        if (match || j_r == '0) begin
          if (!res_full) begin
            res_push            = 1'b1;
            res_d.border_length = BORDER_W'(res_j);
            bord_we             = 1'b1;
            last_j_nxt          = res_j;
            state_nxt           = S_IDLE;
            // overlap: next stored byte starts its walk right away
            if (cmd_valid && cmd_kind == KIND_NEXT) begin
              take_next = 1'b1;
            end
          end
        end else begin
          j_nxt   = bord_q_r;
          rd_addr = bord_q_r;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (take_next) begin
      cmd_pop   = 1'b1;
      text_we   = 1'b1;
      text_wa   = cmd_idx;
      sym_nxt   = cmd_sym;
      idx_nxt   = cmd_idx;
      j_nxt     = last_j_nxt;
      rd_addr   = last_j_nxt;
      state_nxt = S_WALK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    j_r      <= j_nxt;
    last_j_r <= last_j_nxt;
    idx_r    <= idx_nxt;
    sym_r    <= sym_nxt;
  end

  always_ff @(posedge clk) begin
    if (text_we) begin
      text_mem[text_wa] <= cmd_sym;
    end
    text_q_r <= text_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (bord_we) begin
      bord_mem[bord_wa] <= bord_wd;
    end
    bord_q_r <= bord_mem[bord_rd_addr];
  end

endmodule

@@ rtl/kmp_prefix_function.sv @@
// ---------------------------------------------------------------------------
// kmp_prefix_function
// Online KMP prefix function: one border length per input byte.
// ---------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive in_symbol/in_first and raise in_push; the
//   transfer happens on a clock edge with in_push high and in_full low.
//   in_first marks the first byte of a new string (a byte right after reset
//   starts a string on its own).
//   Result side is a queue too: while out_empty is low, out_border_length and
//   out_overflow show the oldest result; raise out_pop to take it.
//   Every byte gives exactly one result, in order. Bytes past MAX_LEN in one
//   string give out_overflow = 1 and border length 0.
// Flow:
//   A byte passes the command queue, the walk unit and the result queue.
//   The walk unit settles a first or overflow byte in its idle state; a
//   stored byte enters the walk state and stays there while it falls back
//   along stored borders. Fallbacks never outnumber bytes. The walk unit
//   takes the next stored byte as it finishes the last one, not before.
// Reset and stall:
//   rst_n (synchronous, active low) empties both queues and clears the
//   string position; memory contents are left alone. A stalled receiver
//   fills the result queue, then the walk unit holds, then in_full rises.
// ---------------------------------------------------------------------------
`include "kmp_prefix_function_assert.svh"

module kmp_prefix_function #(
  parameter int MAX_LEN = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  output logic                             in_full,
  input  logic [kpf_pkg::SYM_W-1:0]        in_symbol,
  input  logic                             in_first,
  output logic                             out_empty,
  input  logic                             out_pop,
  output logic [kpf_pkg::BORDER_W-1:0]     out_border_length,
  output logic                             out_overflow
);
  import kpf_pkg::*;

  localparam int AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CMD_W = $bits(kind_t) + SYM_W + AW;
  localparam int RES_W = $bits(res_t);

  // front -> command queue
  logic             f_push;
  kind_t            f_kind;
  logic [SYM_W-1:0] f_sym;
  logic [AW-1:0]    f_idx;
  logic             cq_full;

  // command queue -> back
  logic [CMD_W-1:0] cq_data;
  logic             cq_valid;
  logic             cq_pop;
  kind_t            b_kind;
  logic [SYM_W-1:0] b_sym;
  logic [AW-1:0]    b_idx;

  // back -> result queue
  logic             res_push;
  logic             res_full;
  res_t             res_d;
  logic [RES_W-1:0] res_q;
  logic             res_valid;
  res_t             res_head;

  kpf_front #(
    .MAX_LEN (MAX_LEN)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_symbol (in_symbol),
    .in_first  (in_first),
    .q_full    (cq_full),
    .cmd_push  (f_push),
    .cmd_kind  (f_kind),
    .cmd_sym   (f_sym),
    .cmd_idx   (f_idx)
  );

  // Decouples classification from the walk so either side can stall.
  kpf_fifo #(
    .WIDTH (CMD_W)
  ) u_cmd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_data ({f_kind, f_sym, f_idx}),
    .full      (cq_full),
    .pop       (cq_pop),
    .pop_data  (cq_data),
    .valid     (cq_valid)
  );

  assign b_kind = kind_t'(cq_data[CMD_W-1 -: $bits(kind_t)]);
  assign b_sym  = cq_data[AW +: SYM_W];
  assign b_idx  = cq_data[AW-1:0];

  kpf_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cq_valid),
    .cmd_kind  (b_kind),
    .cmd_sym   (b_sym),
    .cmd_idx   (b_idx),
    .cmd_pop   (cq_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_d     (res_d)
  );

  // Output result queue: holds finished results while the receiver stalls.
  kpf_fifo #(
    .WIDTH (RES_W)
  ) u_res_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_d),
    .full      (res_full),
    .pop       (out_pop),
    .pop_data  (res_q),
    .valid     (res_valid)
  );

  assign res_head          = res_t'(res_q);
  assign out_empty         = !res_valid;
  assign out_border_length = res_head.border_length;
  assign out_overflow      = res_head.overflow;

  // Walk unit never writes a result into a full queue.
  `KPF_ASSERT_NOW(a_no_push_full, clk, rst_n, res_push, !res_full)
  // Walk unit only takes a command that is actually there.
  `KPF_ASSERT_NOW(a_pop_valid, clk, rst_n, cq_pop, cq_valid)
  // Overflow results never carry a border length.
  `KPF_ASSERT_NOW(a_ovf_zero, clk, rst_n, !out_empty && out_overflow, out_border_length == '0)
  // A pushed byte shows up in the command queue on the next cycle.
  `KPF_ASSERT_NEXT(a_cmd_arrives, clk, rst_n, f_push, cq_valid)

endmodule

@@ sim/kmp_prefix_function_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// kmp_prefix_function_tb
// Self-checking bench for the online KMP prefix function block. Bytes are
// pushed with random gaps, results are popped with random stalls, and every
// result is compared against a local border-length predictor or a typed-in
// expectation. A directed table covers the corner cases, and one long string
// runs past capacity. After that come random strings, mostly periodic or
// small-alphabet, so the fallback walk gets deep.
// ---------------------------------------------------------------------------
module kmp_prefix_function_tb;
  import kpf_pkg::*;

  localparam int MAX_LEN    = 4096;
  localparam int RAND_ITEMS = 1550;
  localparam int DIR_N      = 25;
  localparam int MAX_GAP    = 4;

  // Directed row: byte, first flag, and an optional typed-in expectation.
  // Rows with typed == 0 are checked against the predictor only.
  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             first;
    logic             typed;
    res_t             want;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    // right after reset, no first flag: still starts a string
    '{8'h61, 1'b0, 1'b1, '{1'b0, 12'd0}},
    '{8'h62, 1'b0, 1'b0, '{1'b0, 12'd0}},
    '{8'h61, 1'b0, 1'b0, '{1'b0, 12'd0}},
    '{8'h62, 1'b0, 1'b0, '{1'b0, 12'd0}},
    '{8'h61, 1'b0, 1'b0, '{1'b0, 12'd0}},
    '{8'h63, 1'b0, 1'b0, '{1'b0, 12'd0}},  // walk falls all the way to zero
    // lowest and highest byte values
    '{8'h00, 1'b1, 1'b1, '{1'b0, 12'd0}},
    '{8'h00, 1'b0, 1'b0, '{1'b0, 12'd0}},
    '{8'hFF, 1'b0, 1'b0, '{1'b0, 12'd0}},
    '{8'h00, 1'b0, 1'b0, '{1'b0, 12'd0}},
    '{8'h00, 1'b0, 1'b0, '{1'b0, 12'd0}},
    '{8'hFF, 1'b0, 1'b0, '{1'b0, 12'd0}},
    // "aabaaab": a fallback that stops on a nonzero border
    '{8'h61, 1'b1, 1'b1, '{1'b0, 12'd0}},
    '{8'h61, 1'b0, 1'b0, '{1'b0, 12'd0}},
    '{8'h62, 1'b0, 1'b0, '{1'b0, 12'd0}},
    '{8'h61, 1'b0, 1'b0, '{1'b0, 12'd0}},
    '{8'h61, 1'b0, 1'b0, '{1'b0, 12'd0}},
    '{8'h61, 1'b0, 1'b0, '{1'b0, 12'd0}},
    '{8'h62, 1'b0, 1'b0, '{1'b0, 12'd0}},
    '{8'hFF, 1'b1, 1'b1, '{1'b0, 12'd0}},
    '{8'hFF, 1'b0, 1'b0, '{1'b0, 12'd0}},
    '{8'h80, 1'b0, 1'b0, '{1'b0, 12'd0}},
    '{8'h7F, 1'b0, 1'b0, '{1'b0, 12'd0}},
    // one-byte string followed at once by a restart
    '{8'h55, 1'b1, 1'b1, '{1'b0, 12'd0}},
    '{8'hAA, 1'b1, 1'b1, '{1'b0, 12'd0}}
  };

  logic                clk;
  logic                rst_n;
  logic                in_push;
  logic                in_full;
  logic [SYM_W-1:0]    in_symbol;
  logic                in_first;
  logic                out_empty;
  logic                out_pop;
  logic [BORDER_W-1:0] out_border_length;
  logic                out_overflow;

  kmp_prefix_function #(.MAX_LEN(MAX_LEN)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_symbol         (in_symbol),
    .in_first          (in_first),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_border_length (out_border_length),
    .out_overflow      (out_overflow)
  );

  // 4 ns period
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // ---- predictor state: a private copy of the string and border memories
  logic [SYM_W-1:0]    text_mem   [MAX_LEN];
  logic [BORDER_W-1:0] border_mem [MAX_LEN];
  int                  str_pos;

  // expected results, oldest first
  res_t pending_borders [$];

  // bookkeeping
  int  err_count;
  int  n_bytes;
  int  n_strings;
  int  n_overflow;
  int  n_checked;
  int  peak_border;
  bit  tx_calm;
  bit  rx_calm;
  bit  rx_live;

  // Border length of the prefix ending at s. The walk follows stored
  // borders down until the byte after the border matches s, or the border
  // is empty. Bytes past capacity are dropped and flagged.
  function automatic res_t next_border(input logic [SYM_W-1:0] s, input logic f);
    int   j;
    res_t r;
    if (f || str_pos == 0) n_strings++;
    if (f) str_pos = 0;
    r = '0;
    if (str_pos >= MAX_LEN) begin
      str_pos    = MAX_LEN;
      r.overflow = 1'b1;
      return r;
    end
    text_mem[str_pos] = s;
    j = 0;
    if (str_pos > 0) begin
      j = border_mem[str_pos-1];
      while (j > 0 && text_mem[j] != s) j = border_mem[j-1];
      if (text_mem[j] == s) j++;
    end
    border_mem[str_pos] = BORDER_W'(j);
    str_pos++;
    r.border_length = BORDER_W'(j);
    return r;
  endfunction

  // Per-transfer wait, 0..MAX_GAP; now and then a side switches into a calm
  // stretch with no idling at all, and back.
  function automatic int draw_gap(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Push one byte. Called right after a rising edge (or before the first
  // one); inputs only move on falling edges. With a zero gap in_push stays
  // high across back-to-back transfers, with a single assignment per step.
  task automatic send_byte(input logic [SYM_W-1:0] s, input logic f,
                           input logic typed, input res_t want);
    int   gap;
    res_t pred;
    gap = draw_gap(tx_calm);
    repeat (gap) begin
      @(negedge clk);
      in_push <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_push   <= 1'b1;
    in_symbol <= s;
    in_first  <= f;
    // in_push is high from here on, so the transfer is the first edge with
    // in_full low
    @(posedge clk);
    while (in_full) @(posedge clk);
    pred = next_border(s, f);
    n_bytes++;
    if (pred.overflow) n_overflow++;
    if (int'(pred.border_length) > peak_border) peak_border = int'(pred.border_length);
    pending_borders.insert(pending_borders.size(), typed ? want : pred);
  endtask

  // ---- result side: random stalls on out_pop
  initial begin
    int  gap;
    bit  took;
    out_pop = 1'b0;
    gap     = 0;
    wait (rx_live);
    forever begin
      @(posedge clk);
      took = out_pop && !out_empty;
      @(negedge clk);
      if (took) gap = draw_gap(rx_calm);
      if (gap > 0) begin
        out_pop <= 1'b0;
        gap--;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // ---- checker: every popped result against the oldest expectation
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_borders.size() == 0) begin
        report_mismatch($sformatf("unexpected result border=%0d ovf=%0b",
                                  out_border_length, out_overflow));
      end else begin
        want = pending_borders.pop_front();
        n_checked++;
        if (out_border_length !== want.border_length)
          report_mismatch($sformatf("result %0d: border_length %0d, want %0d",
                                    n_checked, out_border_length, want.border_length));
        if (out_overflow !== want.overflow)
          report_mismatch($sformatf("result %0d: overflow %0b, want %0b",
                                    n_checked, out_overflow, want.overflow));
      end
    end
  end

  // ---- watchdog: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", pending_borders.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // ---- stimulus
  initial begin
    int               k;
    int               len;
    int               kind;
    int               period;
    int               rand_sent;
    logic [SYM_W-1:0] base;
    logic [SYM_W-1:0] motif [5];
    logic [SYM_W-1:0] s;
    logic             f;
    res_t             want;

    err_count   = 0;
    n_bytes     = 0;
    n_strings   = 0;
    n_overflow  = 0;
    n_checked   = 0;
    peak_border = 0;
    str_pos     = 0;
    tx_calm     = 1'b0;
    rx_calm     = 1'b0;
    rx_live     = 1'b0;

    rst_n     = 1'b0;
    in_push   = 1'b0;
    in_symbol = '0;
    in_first  = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n   <= 1'b1;
    rx_live = 1'b1;
    @(posedge clk);

    // directed table
    for (k = 0; k < DIR_N; k++)
      send_byte(DIR_ROWS[k].sym, DIR_ROWS[k].first, DIR_ROWS[k].typed, DIR_ROWS[k].want);

    // one string of a single repeated byte, run past capacity: borders climb
    // to the 12-bit ceiling, then every extra byte is an overflow
    base = SYM_W'($urandom_range(0, 255));
    for (k = 0; k < MAX_LEN + 4; k++) begin
      want = '0;
      if (k == MAX_LEN - 1) want.border_length = BORDER_W'(MAX_LEN - 1);
      if (k >= MAX_LEN)     want.overflow = 1'b1;
      send_byte(base, k == 0, k >= MAX_LEN - 1, want);
    end
    // restart after overflow
    send_byte(base, 1'b1, 1'b1, '0);
    send_byte(base, 1'b0, 1'b0, '0);

    // random strings: periodic and small-alphabet ones drive long fallback
    // walks, a few fully random and noisy ones keep every bit moving
    rand_sent = 0;
    while (rand_sent < RAND_ITEMS) begin
      kind   = $urandom_range(0, 19);
      base   = SYM_W'($urandom_range(0, 255));
      period = $urandom_range(1, 5);
      for (k = 0; k < 5; k++) motif[k] = base + SYM_W'($urandom_range(0, 2));
      if (kind < 10)       len = $urandom_range(1, 48);
      else if (kind < 15)  len = $urandom_range(1, 64);
      else if (kind < 18)  len = $urandom_range(1, 24);
      else if (kind == 18) len = $urandom_range(80, 200);
      else                 len = $urandom_range(1, 16);
      for (k = 0; k < len; k++) begin
        if (kind < 10 || kind == 18) begin
          s = motif[k % period];
          if ($urandom_range(0, 7) == 0) s = base + SYM_W'($urandom_range(0, 2));
        end else if (kind < 15) begin
          s = base + SYM_W'($urandom_range(0, 1));
        end else begin
          s = SYM_W'($urandom_range(0, 255));
        end
        // now and then a string start without the flag: it just continues
        if (kind == 19) f = ($urandom_range(0, 3) == 0);
        else            f = (k == 0) && ($urandom_range(0, 15) != 0);
        send_byte(s, f, 1'b0, '0);
        rand_sent++;
      end
    end

    @(negedge clk);
    in_push <= 1'b0;

    // drain, then a few more cycles to catch stray results
    while (pending_borders.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d bytes in %0d strings, %0d overflow bytes, peak border %0d",
             n_bytes, n_strings, n_overflow, peak_border);
    $display("%0d results compared, %0d mismatches", n_checked, err_count);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
